@@ hw/rtl/pfe_pkg.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Token codes, decoded token kinds, result status codes and the queue entry
// shared by the front end and the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatW = 3;

  // token codes on the input tuser
  localparam logic [FuncW-1:0] FuncPush = 3'd0;
  localparam logic [FuncW-1:0] FuncAdd  = 3'd1;
  localparam logic [FuncW-1:0] FuncSub  = 3'd2;
  localparam logic [FuncW-1:0] FuncMul  = 3'd3;
  localparam logic [FuncW-1:0] FuncDiv  = 3'd4;
  localparam logic [FuncW-1:0] FuncEnd  = 3'd5;

  // token queue between front end and execute unit
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned QCw    = 3;

  typedef enum logic [2:0] {
    KPush,
    KAdd,
    KSub,
    KMul,
    KDiv,
    KEnd,
    KBad
  } kind_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 3'd0,
    StFew      = 3'd1,
    StLeftover = 3'd2,
    StUnknown  = 3'd3,
    StOverflow = 3'd4,
    StDivZero  = 3'd5
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] operand;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfe_front.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator front end
// Accepts tokens, decodes the token code into a kind and queues them for the
// execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [pfe_pkg::DataW-1:0]   s_axis_tdata_i,  // [31:0] operand
  input  wire logic [pfe_pkg::FuncW-1:0]   s_axis_tuser_i,  // [2:0] func
  output logic                             entry_valid_o,
  output pfe_pkg::entry_t                  entry_o,
  input  wire logic                        entry_pop_i
);

  pfe_pkg::entry_t               queue_q [pfe_pkg::QDepth];
  logic [pfe_pkg::QAw-1:0]       wr_ptr_q, wr_ptr_d;
  logic [pfe_pkg::QAw-1:0]       rd_ptr_q, rd_ptr_d;
  logic [pfe_pkg::QCw-1:0]       fill_q, fill_d;
  pfe_pkg::entry_t               dec_entry;
  logic                          push;
  logic                          pop;

  always_comb begin
    dec_entry.operand = s_axis_tdata_i;
    case (s_axis_tuser_i)
      pfe_pkg::FuncPush: dec_entry.kind = pfe_pkg::KPush;
      pfe_pkg::FuncAdd:  dec_entry.kind = pfe_pkg::KAdd;
      pfe_pkg::FuncSub:  dec_entry.kind = pfe_pkg::KSub;
      pfe_pkg::FuncMul:  dec_entry.kind = pfe_pkg::KMul;
      pfe_pkg::FuncDiv:  dec_entry.kind = pfe_pkg::KDiv;
      pfe_pkg::FuncEnd:  dec_entry.kind = pfe_pkg::KEnd;
      default:           dec_entry.kind = pfe_pkg::KBad;
    endcase
  end

  assign s_axis_tready_o = (fill_q != pfe_pkg::QCw'(pfe_pkg::QDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign entry_valid_o   = (fill_q != '0);
  assign pop             = entry_pop_i && entry_valid_o;
  assign entry_o         = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + pfe_pkg::QAw'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + pfe_pkg::QAw'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + pfe_pkg::QCw'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - pfe_pkg::QCw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec_entry;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pfe_pkg::QCw'(pfe_pkg::QDepth))
    else $error("token queue fill beyond depth");

endmodule

`default_nettype wire

@@ hw/rtl/pfe_div.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_div #(
  parameter int unsigned DivW = 48
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [DivW-1:0]           dividend_i,
  input  wire logic [pfe_pkg::DataW-1:0] divisor_i,
  output logic                           done_o,
  output logic [DivW-1:0]                quot_o
);

  localparam int unsigned StepW = $clog2(DivW + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [StepW-1:0]            step_q;
  logic [DivW-1:0]             quot_q;
  logic [pfe_pkg::DataW:0]     rem_q;
  logic [pfe_pkg::DataW-1:0]   dvsr_q;
  logic [pfe_pkg::DataW:0]     rem_sh;
  logic [pfe_pkg::DataW+1:0]   diff;

  assign rem_sh = {rem_q[pfe_pkg::DataW-1:0], quot_q[DivW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvsr_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(DivW);
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[pfe_pkg::DataW+1]) begin
        rem_q  <= diff[pfe_pkg::DataW:0];
        quot_q <= {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[DivW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pfe_exec.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator execute unit
// Runs queued tokens against the operand stack (top entry in a register, the
// rest in a memory) and holds the result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_exec #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        entry_valid_i,
  input  wire pfe_pkg::entry_t             entry_i,
  output logic                             entry_pop_o,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [pfe_pkg::DataW-1:0]        m_axis_tdata_o,  // [31:0] value
  output logic [pfe_pkg::StatW-1:0]        m_axis_tuser_o   // [2:0] status
);

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DivW  = pfe_pkg::DataW + FRAC_BITS;
  localparam logic [CntW-1:0] Full = CntW'(STACK_DEPTH);
  localparam logic [pfe_pkg::DataW-1:0] MaxVal = 32'h7fff_ffff;
  localparam logic [pfe_pkg::DataW-1:0] MinVal = 32'h8000_0000;
  localparam logic [DivW-1:0] TwoP31 = DivW'(1) << 31;

  typedef enum logic [2:0] {
    SIdle,
    SOper,
    SMulSat,
    SDivWait,
    SEmit
  } state_e;

  function automatic logic [pfe_pkg::DataW-1:0] sat64(input logic signed [63:0] v);
    logic [pfe_pkg::DataW-1:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = MaxVal;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = MinVal;
    end else begin
      r = v[pfe_pkg::DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic [pfe_pkg::DataW-1:0] mag32(input logic [pfe_pkg::DataW-1:0] v);
    return v[pfe_pkg::DataW-1] ? (~v + pfe_pkg::DataW'(1)) : v;
  endfunction

  state_e                      state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [pfe_pkg::DataW-1:0]   tos_q, tos_d;
  pfe_pkg::kind_e              op_q, op_d;
  logic signed [63:0]          prod_q, prod_d;
  logic                        neg_q, neg_d;
  logic [pfe_pkg::DataW-1:0]   res_val_q, res_val_d;
  pfe_pkg::status_e            res_st_q, res_st_d;
  logic                        ovalid_q, ovalid_d;
  logic [pfe_pkg::DataW-1:0]   odata_q, odata_d;
  logic [pfe_pkg::StatW-1:0]   ouser_q, ouser_d;

  logic [pfe_pkg::DataW-1:0]   mem [STACK_DEPTH];
  logic [pfe_pkg::DataW-1:0]   rd_data_q;
  logic [AddrW-1:0]            rd_addr;
  logic                        mem_we;
  logic [AddrW-1:0]            wr_addr;
  logic [CntW-1:0]             cnt_m1;
  logic [CntW-1:0]             cnt_m2;

  logic signed [pfe_pkg::DataW-1:0] left_s, right_s;
  logic [pfe_pkg::DataW:0]     sum;
  logic [pfe_pkg::DataW-1:0]   sum_sat;
  logic signed [63:0]          shifted;
  logic                        div_start;
  logic                        div_done;
  logic [DivW-1:0]             div_quot;
  logic [DivW-1:0]             dividend;
  logic                        quot_big;
  logic [pfe_pkg::DataW-1:0]   div_res;

  assign cnt_m1  = cnt_q - CntW'(1);
  assign cnt_m2  = cnt_q - CntW'(2);
  assign rd_addr = cnt_m2[AddrW-1:0];
  assign wr_addr = cnt_m1[AddrW-1:0];

  assign left_s  = rd_data_q;
  assign right_s = tos_q;

  always_comb begin
    if (op_q == pfe_pkg::KSub) begin
      sum = {left_s[pfe_pkg::DataW-1], left_s} - {right_s[pfe_pkg::DataW-1], right_s};
    end else begin
      sum = {left_s[pfe_pkg::DataW-1], left_s} + {right_s[pfe_pkg::DataW-1], right_s};
    end
    if (sum[pfe_pkg::DataW] != sum[pfe_pkg::DataW-1]) begin
      sum_sat = sum[pfe_pkg::DataW] ? MinVal : MaxVal;
    end else begin
      sum_sat = sum[pfe_pkg::DataW-1:0];
    end
  end

  // floor shift of the product
  assign shifted  = prod_q >>> FRAC_BITS;
  assign dividend = DivW'(mag32(rd_data_q)) << FRAC_BITS;

  always_comb begin
    quot_big = ((div_quot >> 31) != '0);
    if (neg_q) begin
      div_res = (quot_big && (div_quot != TwoP31)) ? MinVal
              : (~div_quot[pfe_pkg::DataW-1:0] + pfe_pkg::DataW'(1));
    end else begin
      div_res = quot_big ? MaxVal : div_quot[pfe_pkg::DataW-1:0];
    end
  end

  pfe_div #(
    .DivW (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (mag32(tos_q)),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tos_d       = tos_q;
    op_d        = op_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    ovalid_d    = ovalid_q && !m_axis_tready_i;
    odata_d     = odata_q;
    ouser_d     = ouser_q;
    entry_pop_o = 1'b0;
    mem_we      = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      SIdle: begin
        if (entry_valid_i) begin
          entry_pop_o = 1'b1;
          op_d        = entry_i.kind;
          case (entry_i.kind)
            pfe_pkg::KPush: begin
              if (cnt_q == Full) begin
                cnt_d     = '0;
                res_val_d = '0;
                res_st_d  = pfe_pkg::StOverflow;
                state_d   = SEmit;
              end else begin
                // spill the old top into the memory
                mem_we = (cnt_q != '0);
                tos_d  = entry_i.operand;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            pfe_pkg::KEnd: begin
              cnt_d   = '0;
              state_d = SEmit;
              if (cnt_q == CntW'(1)) begin
                res_val_d = tos_q;
                res_st_d  = pfe_pkg::StOk;
              end else begin
                res_val_d = '0;
                res_st_d  = pfe_pkg::StLeftover;
              end
            end
            default: begin
              if (cnt_q < CntW'(2)) begin
                cnt_d     = '0;
                res_val_d = '0;
                res_st_d  = pfe_pkg::StFew;
                state_d   = SEmit;
              end else if (entry_i.kind == pfe_pkg::KBad) begin
                cnt_d     = '0;
                res_val_d = '0;
                res_st_d  = pfe_pkg::StUnknown;
                state_d   = SEmit;
              end else begin
                state_d = SOper;
              end
            end
          endcase
        end
      end

      SOper: begin
        case (op_q)
          pfe_pkg::KMul: begin
            prod_d  = left_s * right_s;
            state_d = SMulSat;
          end
          pfe_pkg::KDiv: begin
            if (tos_q == '0) begin
              cnt_d     = '0;
              res_val_d = '0;
              res_st_d  = pfe_pkg::StDivZero;
              state_d   = SEmit;
            end else begin
              div_start = 1'b1;
              neg_d     = left_s[pfe_pkg::DataW-1] ^ right_s[pfe_pkg::DataW-1];
              state_d   = SDivWait;
            end
          end
          default: begin
            tos_d   = sum_sat;
            cnt_d   = cnt_m1;
            state_d = SIdle;
          end
        endcase
      end

      SMulSat: begin
        tos_d   = sat64(shifted);
        cnt_d   = cnt_m1;
        state_d = SIdle;
      end

      SDivWait: begin
        if (div_done) begin
          tos_d   = div_res;
          cnt_d   = cnt_m1;
          state_d = SIdle;
        end
      end

      SEmit: begin
        // hold until the output register frees up
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = res_val_q;
          ouser_d  = res_st_q;
          state_d  = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q     <= tos_d;
    op_q      <= op_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    odata_q   <= odata_d;
    ouser_q   <= ouser_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= tos_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("stack count beyond depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit && res_st_q != pfe_pkg::StOk) |-> (res_val_q == '0))
    else $error("error result carries a nonzero value");

  a_oper_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOper) |-> (cnt_q >= CntW'(2)))
    else $error("operator executed with fewer than two entries");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == SDivWait))
    else $error("divider finished outside a divide");

endmodule

`default_nettype wire

@@ hw/rtl/postfix_expression_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates postfix token streams on a signed fixed-point operand stack.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens enter on the s_axis channel: tuser carries the token code (push,
//   add, subtract, multiply, divide, end), tdata the number to push.
//   Results leave on the m_axis channel: tdata the value, tuser the status.
//   Only an end token or an error produces a result; an error empties the
//   stack and drops the expression under way.
//   A four-entry token queue separates the front end from the execute unit.
//   In the execute unit a push completes in the idle state, add and subtract
//   pass through the operate state, multiply also through the saturate state,
//   divide through the operate state and the divider wait (one quotient bit
//   per cycle in the divider), and a token that produces a result through emit.
//   After reset the stack and the queue are empty.
//   While the receiver stalls the result stays in the output register;
//   the next result waits in the execute unit, and tokens keep queuing
//   until the queue fills, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [pfe_pkg::DataW-1:0] s_axis_tdata_i,  // [31:0] operand
  input  wire logic [pfe_pkg::FuncW-1:0] s_axis_tuser_i,  // [2:0] func
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [pfe_pkg::DataW-1:0]      m_axis_tdata_o,  // [31:0] value
  output logic [pfe_pkg::StatW-1:0]      m_axis_tuser_o   // [2:0] status
);

  logic            entry_valid;
  logic            entry_pop;
  pfe_pkg::entry_t entry;

  pfe_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .entry_valid_o   (entry_valid),
    .entry_o         (entry),
    .entry_pop_i     (entry_pop)
  );

  pfe_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_exec (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (entry_valid),
    .entry_i         (entry),
    .entry_pop_o     (entry_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

@@ test/pfe_outcome_checker.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator outcome checker
// Watches both stream channels of the evaluator. Each accepted token is run
// through a local copy of the operand stack, and the results it must cause
// are queued. Each accepted result is compared against the oldest one queued.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_outcome_checker #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [pfe_pkg::DataW-1:0]  s_tdata_i,   // [31:0] operand
  input  logic [pfe_pkg::FuncW-1:0]  s_tuser_i,   // [2:0] func
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic [pfe_pkg::DataW-1:0]  m_tdata_i,   // [31:0] value
  input  logic [pfe_pkg::StatW-1:0]  m_tuser_i,   // [2:0] status
  output int unsigned                errors_o,
  output int unsigned                pending_o
);

  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  typedef struct {
    logic [pfe_pkg::DataW-1:0] value;
    pfe_pkg::status_e          status;
  } outcome_t;

  outcome_t                         outcome_q[$];
  logic signed [pfe_pkg::DataW-1:0] stack_mem[STACK_DEPTH];
  int unsigned                      stack_depth = 0;
  int unsigned                      err_count   = 0;
  int unsigned                      open_count  = 0;

  assign errors_o  = err_count;
  assign pending_o = open_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [pfe_pkg::DataW-1:0] clamp32(input longint v);
    if (v > SatHi) return SatHi[pfe_pkg::DataW-1:0];
    if (v < SatLo) return SatLo[pfe_pkg::DataW-1:0];
    return v[pfe_pkg::DataW-1:0];
  endfunction

  task automatic abort_expr(input pfe_pkg::status_e status);
    outcome_t o;
    stack_depth = 0;
    o.value     = '0;
    o.status    = status;
    outcome_q.push_back(o);
  endtask

  task automatic evaluate_token(input logic [pfe_pkg::FuncW-1:0] func,
                                input logic [pfe_pkg::DataW-1:0] operand);
    outcome_t o;
    longint   lhs;
    longint   rhs;
    longint   res;
    if (func == pfe_pkg::FuncPush) begin
      if (stack_depth >= STACK_DEPTH) begin
        abort_expr(pfe_pkg::StOverflow);
      end else begin
        stack_mem[stack_depth] = operand;
        stack_depth++;
      end
    end else if (func == pfe_pkg::FuncEnd) begin
      if (stack_depth != 1) begin
        abort_expr(pfe_pkg::StLeftover);
      end else begin
        stack_depth = 0;
        o.value     = stack_mem[0];
        o.status    = pfe_pkg::StOk;
        outcome_q.push_back(o);
      end
    end else if (stack_depth < 2) begin
      // operand count is checked before the code is decoded
      abort_expr(pfe_pkg::StFew);
    end else if (func > pfe_pkg::FuncEnd) begin
      abort_expr(pfe_pkg::StUnknown);
    end else begin
      rhs = longint'(stack_mem[stack_depth-1]);
      lhs = longint'(stack_mem[stack_depth-2]);
      if (func == pfe_pkg::FuncDiv && rhs == 0) begin
        abort_expr(pfe_pkg::StDivZero);
      end else begin
        case (func)
          pfe_pkg::FuncAdd: res = lhs + rhs;
          pfe_pkg::FuncSub: res = lhs - rhs;
          pfe_pkg::FuncMul: res = (lhs * rhs) >>> FRAC_BITS;  // floor
          default:          res = (lhs <<< FRAC_BITS) / rhs;  // truncate toward zero
        endcase
        stack_depth--;
        stack_mem[stack_depth-1] = clamp32(res);
      end
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %08h status %0d",
                                    m_tdata_i, m_tuser_i));
        end else begin
          o = outcome_q.pop_front();
          if (m_tdata_i !== o.value)
            report_mismatch($sformatf("value %08h, predicted %08h",
                                      m_tdata_i, o.value));
          if (m_tuser_i !== o.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      m_tuser_i, o.status));
        end
      end
      if (s_tvalid_i && s_tready_i) evaluate_token(s_tuser_i, s_tdata_i);
      open_count = outcome_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Postfix evaluator testbench
// Drives token streams into the evaluator: a directed set of corner cases,
// then random expressions, deep stacks and noise, with random gaps on the
// token side and random stalls on the result side. The outcome checker
// predicts and compares; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned StackDepth   = 16;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned TokenTarget  = 1900;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned CalmBlock    = 150;
  localparam longint      RunLimitNs   = 4_000_000;

  localparam logic [pfe_pkg::FuncW-1:0] FuncUnknownLo = 3'd6;
  localparam logic [pfe_pkg::FuncW-1:0] FuncUnknownHi = 3'd7;

  localparam logic [pfe_pkg::DataW-1:0] QMax    = 32'h7fff_ffff;
  localparam logic [pfe_pkg::DataW-1:0] QMin    = 32'h8000_0000;
  localparam logic [pfe_pkg::DataW-1:0] QOne    = 32'h0001_0000;
  localparam logic [pfe_pkg::DataW-1:0] QNegOne = 32'hffff_0000;
  localparam logic [pfe_pkg::DataW-1:0] QLsbNeg = 32'hffff_ffff;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic [pfe_pkg::DataW-1:0] in_operand = '0;
  logic [pfe_pkg::FuncW-1:0] in_func    = pfe_pkg::FuncPush;
  logic                      out_ready  = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic [pfe_pkg::DataW-1:0] out_value;
  logic [pfe_pkg::StatW-1:0] out_status;

  int unsigned errors;
  int unsigned pending;
  int unsigned sent = 0;
  logic        calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  postfix_expression_evaluator_unit #(
    .STACK_DEPTH (StackDepth),
    .FRAC_BITS   (FracBits)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_operand),
    .s_axis_tuser_i  (in_func),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_value),
    .m_axis_tuser_o  (out_status)
  );

  pfe_outcome_checker #(
    .STACK_DEPTH (StackDepth),
    .FRAC_BITS   (FracBits)
  ) i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (in_valid),
    .s_tready_i (in_ready),
    .s_tdata_i  (in_operand),
    .s_tuser_i  (in_func),
    .m_tvalid_i (out_valid),
    .m_tready_i (out_ready),
    .m_tdata_i  (out_value),
    .m_tuser_i  (out_status),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [pfe_pkg::DataW-1:0] rand_operand();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 5))
          0:       return QMax;
          1:       return QMin;
          2:       return QOne;
          3:       return QNegOne;
          4:       return QLsbNeg;
          default: return '0;
        endcase
      end
      1, 2, 3: return $urandom();
      4:       return '0;
      // small magnitudes, within +/- 8.0
      default: return pfe_pkg::DataW'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [pfe_pkg::FuncW-1:0] rand_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return pfe_pkg::FuncAdd;
    if (r < 55) return pfe_pkg::FuncSub;
    if (r < 80) return pfe_pkg::FuncMul;
    if (r < 97) return pfe_pkg::FuncDiv;
    if (r < 99) return FuncUnknownLo;
    return FuncUnknownHi;
  endfunction

  task automatic send_token(input logic [pfe_pkg::FuncW-1:0] func,
                            input logic [pfe_pkg::DataW-1:0] operand);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_func    <= func;
    in_operand <= operand;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic push_pair_op(input logic [pfe_pkg::DataW-1:0] lhs,
                              input logic [pfe_pkg::DataW-1:0] rhs,
                              input logic [pfe_pkg::FuncW-1:0] op);
    send_token(pfe_pkg::FuncPush, lhs);
    send_token(pfe_pkg::FuncPush, rhs);
    send_token(op, $urandom());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // well-formed expression over the given number of operands
  task automatic send_expression(input int unsigned leaves);
    int unsigned held;
    held = 0;
    while (leaves > 0 || held > 1) begin
      if (held < 2 || (leaves > 0 && $urandom_range(0, 1) == 1)) begin
        send_token(pfe_pkg::FuncPush, rand_operand());
        leaves--;
        held++;
      end else begin
        send_token(rand_op(), $urandom());
        held--;
      end
    end
    send_token(pfe_pkg::FuncEnd, $urandom());
  endtask

  task automatic send_deep_stack();
    repeat (StackDepth) send_token(pfe_pkg::FuncPush, rand_operand());
    if ($urandom_range(0, 1) == 1) begin
      // one push too many empties the stack
      send_token(pfe_pkg::FuncPush, rand_operand());
    end else begin
      repeat (StackDepth - 1) send_token(rand_op(), $urandom());
      send_token(pfe_pkg::FuncEnd, $urandom());
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_token(pfe_pkg::FuncW'($urandom_range(0, 7)), $urandom());
    if ($urandom_range(0, 1) == 1) send_token(pfe_pkg::FuncEnd, $urandom());
  endtask

  // result side: ready bursts broken by random stalls
  initial begin
    int unsigned burst;
    @(posedge rst_n);
    forever begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (pick_gap()) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned next_switch;
    int unsigned r;
    logic        paused;
    next_switch = CalmBlock;
    paused      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner cases
    send_token(pfe_pkg::FuncEnd, QMax);
    send_token(FuncUnknownHi, QMin);
    push_pair_op(QMax, QMax, pfe_pkg::FuncAdd);
    send_token(pfe_pkg::FuncEnd, '0);
    push_pair_op(QMin, QMax, pfe_pkg::FuncSub);
    send_token(pfe_pkg::FuncEnd, '0);
    push_pair_op(QMin, QMin, pfe_pkg::FuncMul);
    send_token(pfe_pkg::FuncEnd, '0);
    push_pair_op(QMin, QLsbNeg, pfe_pkg::FuncDiv);
    send_token(pfe_pkg::FuncEnd, '0);
    push_pair_op(QOne, '0, pfe_pkg::FuncDiv);
    push_pair_op(QNegOne, QOne, FuncUnknownLo);
    send_token(pfe_pkg::FuncPush, QOne);
    send_token(pfe_pkg::FuncPush, QLsbNeg);
    send_token(pfe_pkg::FuncEnd, '0);

    while (sent < TokenTarget) begin
      if (sent >= next_switch) begin
        calm        = ($urandom_range(0, 4) == 0);
        next_switch = next_switch + CalmBlock;
      end
      if (!paused && sent >= TokenTarget / 2) begin
        drain_results();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 4)       send_deep_stack();
      else if (r < 70) send_expression($urandom_range(1, 4));
      else if (r < 82) send_expression($urandom_range(5, StackDepth));
      else             send_noise();
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_front.sv
hw/rtl/pfe_div.sv
hw/rtl/pfe_exec.sv
hw/rtl/postfix_expression_evaluator_unit.sv
test/pfe_outcome_checker.sv
test/tb_top.sv
